[rtl/core/radiance_to_brightness_temperature_macros.svh]
// Assertion macros for the radiance to brightness temperature block.
// Included by the top level; needs nothing else.
`ifndef RADIANCE_TO_BRIGHTNESS_TEMPERATURE_MACROS_SVH
`define RADIANCE_TO_BRIGHTNESS_TEMPERATURE_MACROS_SVH

// Same-cycle implication under an active-low synchronous reset.
`define RTBT_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication under an active-low synchronous reset.
`define RTBT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

[rtl/core/rtbt_pkg.sv]
// Shared types and constants for the radiance to brightness temperature block.
// No dependencies.
package rtbt_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int FRAC_BITS      = 30;
    localparam int VAL_BITS       = 41;
    localparam int EXP_BITS       = 6;
    localparam int LOG_BITS       = EXP_BITS + FRAC_BITS;
    localparam int LNQ_BITS       = 36;
    localparam int TEMP_BITS      = 16;
    localparam int NUMER_BITS     = 53;

    // ln2 in Q.28
    localparam logic [27:0] LN2_Q28 = 28'd186065280;

    typedef enum logic [1:0] {
        CFG_GAIN      = 2'd0,
        CFG_OFFSET    = 2'd1,
        CFG_RATIO     = 2'd2,
        CFG_NUMERATOR = 2'd3
    } t_cfg_idx;

    // Sideband that travels with each item down the pipeline
    typedef struct packed {
        logic valid;
        logic inval;
        logic last;
    } t_side;

    // Index of the highest set bit, zero for a zero word
    function automatic logic [EXP_BITS-1:0] top_bit(input logic [VAL_BITS-1:0] v);
        logic [EXP_BITS-1:0] e;
        e = '0;
        for (int i = 0; i < VAL_BITS; i++) begin
            if (v[i]) begin
                e = EXP_BITS'(i);
            end
        end
        return e;
    endfunction

endpackage

[rtl/core/radiance_to_brightness_temperature.sv]
// Converts raw infrared pixel counts to brightness temperature in 1/128 K.
// Depends on rtbt_pkg, rtbt_log2diff, rtbt_div and the assertion macro header.
//
// One pixel enters per cycle while the pipeline advances; the depth is set by
// the two 30-round squaring chains of the log2 lanes and the divider. The whole
// pipeline advances when the output register is empty or being taken, so a
// stalled output holds every stage. Load the four constants while no pixel is
// in flight.
`include "radiance_to_brightness_temperature_macros.svh"

module radiance_to_brightness_temperature #(
    parameter int COUNT_BITS = rtbt_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_pixel_count,
    input  logic        i_last_pixel,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_temperature,
    output logic        o_invalid,
    output logic        o_end_of_image
);

    logic [31:0] r_gain, r_offset, r_ratio, r_numer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= '0;
            r_offset <= '0;
            r_ratio  <= '0;
            r_numer  <= '0;
        end else if (i_cfg_we) begin
            unique case (rtbt_pkg::t_cfg_idx'(i_cfg_index))
                rtbt_pkg::CFG_GAIN:      r_gain   <= i_cfg_data;
                rtbt_pkg::CFG_OFFSET:    r_offset <= i_cfg_data;
                rtbt_pkg::CFG_RATIO:     r_ratio  <= i_cfg_data;
                rtbt_pkg::CFG_NUMERATOR: r_numer  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_out_valid;
    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // Stage 1: radiance in Q.24
    logic [COUNT_BITS-1:0] w_count;
    logic signed [16:0]    w_count_s;
    logic signed [48:0]    w_prod, w_off;
    assign w_count   = i_pixel_count[COUNT_BITS-1:0];
    assign w_count_s = $signed({{(17-COUNT_BITS){1'b0}}, w_count});
    assign w_prod    = $signed(r_gain) * w_count_s;
    assign w_off     = $signed({{9{r_offset[31]}}, r_offset, 8'b0});

    logic signed [48:0] r_rad;
    rtbt_pkg::t_side    r_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (w_en) begin
            r_s1 <= '{valid: i_in_valid, inval: 1'b0, last: i_last_pixel};
        end
        if (w_en) begin
            r_rad <= w_prod + w_off;
        end
    end

    // Stage 2: Q.16 radiance and the log numerator
    logic [rtbt_pkg::VAL_BITS-1:0] r_num, r_den;
    rtbt_pkg::t_side               r_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else if (w_en) begin
            r_s2 <= '{valid: r_s1.valid, inval: (r_rad < 49'sd256), last: r_s1.last};
        end
        if (w_en) begin
            r_den <= {1'b0, r_rad[47:8]};
            r_num <= {1'b0, r_rad[47:8]} + {1'b0, r_ratio, 8'b0};
        end
    end

    logic [rtbt_pkg::LOG_BITS-1:0] w_d;
    rtbt_pkg::t_side               w_s3;

    rtbt_log2diff u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_side  (r_s2),
        .o_d     (w_d),
        .o_side  (w_s3)
    );

    // Scale by ln2: split the 36-bit difference into two partial products
    logic [45:0]     r_pp_hi, r_pp_lo;
    rtbt_pkg::t_side r_s4;
    logic [63:0]     w_sum;
    logic [rtbt_pkg::LNQ_BITS-1:0] r_lnq;
    rtbt_pkg::t_side r_s5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4 <= '0;
            r_s5 <= '0;
        end else if (w_en) begin
            r_s4 <= w_s3;
            r_s5 <= r_s4;
        end
        if (w_en) begin
            r_pp_hi <= w_d[35:18] * rtbt_pkg::LN2_Q28;
            r_pp_lo <= w_d[17:0] * rtbt_pkg::LN2_Q28;
            r_lnq   <= w_sum[63:28];
        end
    end

    assign w_sum = {r_pp_hi, 18'b0} + 64'(r_pp_lo) + 64'h0000_0000_0800_0000;

    logic [15:0]     w_q;
    logic            w_sat;
    rtbt_pkg::t_side w_s6;

    rtbt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_lnq   (r_lnq),
        .i_numc  (r_numer),
        .i_side  (r_s5),
        .o_q     (w_q),
        .o_sat   (w_sat),
        .o_side  (w_s6)
    );

    logic [15:0] r_temp;
    logic        r_inval, r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_s6.valid;
        end
        if (w_en) begin
            r_temp  <= w_s6.inval ? 16'h0000 : (w_sat ? 16'hFFFF : w_q);
            r_inval <= w_s6.inval;
            r_last  <= w_s6.last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_temperature  = r_temp;
    assign o_invalid      = r_inval;
    assign o_end_of_image = r_last;

    `RTBT_ASSERT_NOW(a_inval_zero, i_clk, i_rst_n, o_out_valid && o_invalid, o_temperature == 16'h0000)
    `RTBT_ASSERT_NOW(a_stall_only_on_output, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready)
    `RTBT_ASSERT_NEXT(a_low_rad_flagged, i_clk, i_rst_n, w_en && r_s1.valid && (r_rad < 49'sd256), r_s2.inval)

endmodule

[rtl/core/rtbt_log2diff.sv]
// Pipelined log2 of two values in Q.30 and their difference.
// Depends on rtbt_pkg.
module rtbt_log2diff (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic [rtbt_pkg::VAL_BITS-1:0]     i_num,
    input  logic [rtbt_pkg::VAL_BITS-1:0]     i_den,
    input  rtbt_pkg::t_side                   i_side,
    output logic [rtbt_pkg::LOG_BITS-1:0]     o_d,
    output rtbt_pkg::t_side                   o_side
);

    localparam int FB = rtbt_pkg::FRAC_BITS;
    localparam int EB = rtbt_pkg::EXP_BITS;
    localparam int VB = rtbt_pkg::VAL_BITS;

    // One round of squaring: returns {fraction bit, new mantissa}
    function automatic logic [FB+1:0] sq_step(input logic [FB:0] m);
        logic [2*FB+1:0] sq;
        logic [FB+1:0]   t;
        sq = m * m;
        t  = sq[2*FB+1:FB];
        if (t[FB+1]) begin
            return {1'b1, t[FB+1:1]};
        end
        return {1'b0, t[FB:0]};
    endfunction

    function automatic logic [FB:0] norm(input logic [VB-1:0] v, input logic [EB-1:0] e);
        logic [VB-1:0] s;
        if (e >= EB'(FB)) begin
            s = v >> (e - EB'(FB));
        end else begin
            s = v << (EB'(FB) - e);
        end
        return s[FB:0];
    endfunction

    logic [VB-1:0]      r_va_n, r_va_d;
    logic [EB-1:0]      r_ea_n, r_ea_d;
    rtbt_pkg::t_side    r_sa;

    logic [FB:0]        r_m_n [0:FB];
    logic [FB:0]        r_m_d [0:FB];
    logic [EB-1:0]      r_e_n [0:FB];
    logic [EB-1:0]      r_e_d [0:FB];
    logic [FB-1:0]      r_f_n [0:FB];
    logic [FB-1:0]      r_f_d [0:FB];
    rtbt_pkg::t_side    r_s   [0:FB];

    logic [rtbt_pkg::LOG_BITS-1:0] r_d;
    rtbt_pkg::t_side               r_sd;

    // Leading-one search
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa <= '0;
        end else if (i_en) begin
            r_sa <= i_side;
        end
        if (i_en) begin
            r_va_n <= i_num;
            r_va_d <= i_den;
            r_ea_n <= rtbt_pkg::top_bit(i_num);
            r_ea_d <= rtbt_pkg::top_bit(i_den);
        end
    end

    // Normalise to a Q.30 mantissa
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s[0] <= '0;
        end else if (i_en) begin
            r_s[0] <= r_sa;
        end
        if (i_en) begin
            r_m_n[0] <= norm(r_va_n, r_ea_n);
            r_m_d[0] <= norm(r_va_d, r_ea_d);
            r_e_n[0] <= r_ea_n;
            r_e_d[0] <= r_ea_d;
            r_f_n[0] <= '0;
            r_f_d[0] <= '0;
        end
    end

    for (genvar k = 1; k <= FB; k++) begin : g_sq
        logic [FB+1:0] w_n, w_d;
        assign w_n = sq_step(r_m_n[k-1]);
        assign w_d = sq_step(r_m_d[k-1]);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s[k] <= '0;
            end else if (i_en) begin
                r_s[k] <= r_s[k-1];
            end
            if (i_en) begin
                r_m_n[k] <= w_n[FB:0];
                r_m_d[k] <= w_d[FB:0];
                r_f_n[k] <= {r_f_n[k-1][FB-2:0], w_n[FB+1]};
                r_f_d[k] <= {r_f_d[k-1][FB-2:0], w_d[FB+1]};
                r_e_n[k] <= r_e_n[k-1];
                r_e_d[k] <= r_e_d[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd <= '0;
        end else if (i_en) begin
            r_sd <= r_s[FB];
        end
        if (i_en) begin
            r_d <= {r_e_n[FB], r_f_n[FB]} - {r_e_d[FB], r_f_d[FB]};
        end
    end

    assign o_d    = r_d;
    assign o_side = r_sd;

endmodule

[rtl/core/rtbt_div.sv]
// Pipelined restoring divider, one quotient bit a stage, with saturation.
// Depends on rtbt_pkg.
module rtbt_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic [rtbt_pkg::LNQ_BITS-1:0]     i_lnq,
    input  logic [31:0]                       i_numc,
    input  rtbt_pkg::t_side                   i_side,
    output logic [rtbt_pkg::TEMP_BITS-1:0]    o_q,
    output logic                              o_sat,
    output rtbt_pkg::t_side                   o_side
);

    localparam int QB = rtbt_pkg::TEMP_BITS;
    localparam int NB = rtbt_pkg::NUMER_BITS;
    localparam int LB = rtbt_pkg::LNQ_BITS;

    logic [NB-1:0]   r_rem [0:QB];
    logic [LB-1:0]   r_dv  [0:QB];
    logic [QB-1:0]   r_q   [0:QB];
    logic            r_sat [0:QB];
    rtbt_pkg::t_side r_s   [0:QB];

    logic [NB-1:0] w_n;
    assign w_n = {i_numc, 21'b0};

    // Quotient beyond the output range, also a zero divisor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s[0] <= '0;
        end else if (i_en) begin
            r_s[0] <= i_side;
        end
        if (i_en) begin
            r_rem[0] <= w_n;
            r_dv[0]  <= i_lnq;
            r_q[0]   <= '0;
            r_sat[0] <= w_n >= (NB'(i_lnq) << QB);
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_bit
        logic [NB-1:0] w_sub;
        logic          w_ge;
        assign w_sub = NB'(r_dv[j-1]) << (QB - j);
        assign w_ge  = r_rem[j-1] >= w_sub;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s[j] <= '0;
            end else if (i_en) begin
                r_s[j] <= r_s[j-1];
            end
            if (i_en) begin
                r_rem[j] <= w_ge ? r_rem[j-1] - w_sub : r_rem[j-1];
                r_dv[j]  <= r_dv[j-1];
                r_q[j]   <= {r_q[j-1][QB-2:0], w_ge};
                r_sat[j] <= r_sat[j-1];
            end
        end
    end

    assign o_q    = r_q[QB];
    assign o_sat  = r_sat[QB];
    assign o_side = r_s[QB];

endmodule
